// ===== rtl/prefix_acl_server_client_check_unit_macros.svh =====
// Assertion macros shared by the access-list RTL.
`ifndef PREFIX_ACL_SERVER_CLIENT_CHECK_UNIT_MACROS_SVH
`define PREFIX_ACL_SERVER_CLIENT_CHECK_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PACL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pacl assertion failed");
`define PACL_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("pacl forbidden condition");
`else
`define PACL_ASSERT(lbl, prop)
`define PACL_NEVER(lbl, expr)
`endif
`endif

// ===== rtl/pacl_pkg.sv =====
// Types and constants of the prefix access list.
`timescale 1ns / 1ps
package pacl_pkg;

  localparam logic [31:0] LOCALHOST_ADDR = 32'h7F00_0001;

  typedef enum logic [2:0] {
    OUT_LOCALHOST = 3'd0,
    OUT_ALLOWED   = 3'd1,
    OUT_NO_SERVER = 3'd2,
    OUT_DENIED    = 3'd3,
    OUT_WRITTEN   = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_LOCAL = 2'd1,
    OP_CHECK = 2'd2
  } op_t;

  typedef struct packed {
    logic        is_server;
    logic [31:0] address;
    logic [5:0]  prefix;
    logic        has_cookie;
    logic [63:0] cookie;
  } rule_t;

  typedef struct packed {
    op_t         op;
    logic        idx_ok;
    logic [3:0]  idx;
    rule_t       rule;
    logic [31:0] srv;
    logic [31:0] cli;
    logic        rhas;
    logic [63:0] rtok;
  } cmd_t;

  typedef struct packed {
    logic     allowed;
    outcome_t outcome;
  } result_t;

  // leading-ones mask; zero or oversize prefix matches everything
  function automatic logic [31:0] prefix_mask(input logic [5:0] p);
    logic [31:0] m;
    if (p == 6'd0 || p > 6'd32) begin
      m = '0;
    end else begin
      m = ~(32'hFFFF_FFFF >> p);
    end
    return m;
  endfunction

endpackage

// ===== rtl/pacl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pacl_fifo.sv =====
// Small synchronous queue with full and empty flags.
`timescale 1ns / 1ps
`include "prefix_acl_server_client_check_unit_macros.svh"
module pacl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `PACL_ASSERT(a_count_range, count_r <= CW'(DEPTH))
  `PACL_ASSERT(a_push_grows, (do_push && !do_pop) |=> !empty)
  `PACL_ASSERT(a_pop_shrinks, (do_pop && !do_push) |=> !full)

endmodule

// ===== rtl/pacl_front.sv =====
// Front end: takes input items, classifies them and queues commands.
`timescale 1ns / 1ps
module pacl_front #(
  parameter int MAX_RULES = 16
) (
  input  logic            in_push,
  output logic            in_full,
  input  logic            in_command,
  input  logic [3:0]      in_rule_index,
  input  logic            in_rule_is_server,
  input  logic [31:0]     in_rule_address,
  input  logic [5:0]      in_rule_prefix,
  input  logic            in_rule_has_cookie,
  input  logic [63:0]     in_rule_cookie,
  input  logic [31:0]     in_server_address,
  input  logic [31:0]     in_client_address,
  input  logic            in_request_has_cookie,
  input  logic [63:0]     in_request_cookie,
  output logic            q_push,
  output pacl_pkg::cmd_t  q_data,
  input  logic            q_full
);

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  always_comb begin
    q_data                 = '0;
    q_data.idx             = in_rule_index;
    q_data.idx_ok          = (32'(in_rule_index) < MAX_RULES);
    q_data.rule.is_server  = in_rule_is_server;
    q_data.rule.address    = in_rule_address;
    q_data.rule.prefix     = in_rule_prefix;
    q_data.rule.has_cookie = in_rule_has_cookie;
    q_data.rule.cookie     = in_rule_cookie;
    q_data.srv             = in_server_address;
    q_data.cli             = in_client_address;
    q_data.rhas            = in_request_has_cookie;
    q_data.rtok            = in_request_cookie;
    if (!in_command) begin
      q_data.op = pacl_pkg::OP_WRITE;
    end else if (in_server_address == pacl_pkg::LOCALHOST_ADDR) begin
      q_data.op = pacl_pkg::OP_LOCAL;
    end else begin
      q_data.op = pacl_pkg::OP_CHECK;
    end
  end

endmodule

// ===== rtl/pacl_back.sv =====
// Back end: writes rules and walks the rule table for checks.
`timescale 1ns / 1ps
`include "prefix_acl_server_client_check_unit_macros.svh"
module pacl_back #(
  parameter int MAX_RULES = 16,
  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [4:0]        rule_count,
  input  pacl_pkg::cmd_t    q_data,
  input  logic              q_empty,
  output logic              q_pop,
  input  logic              res_full,
  output logic              res_push,
  output pacl_pkg::result_t res_data,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output pacl_pkg::rule_t   ram_wdata,
  output logic [AW-1:0]     ram_raddr,
  input  pacl_pkg::rule_t   ram_rdata
);

  localparam int CW = $clog2(MAX_RULES + 1);

  typedef enum logic {S_IDLE, S_WALK} state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic           srvf_r, srvf_nxt, found_r, found_nxt;
  logic           ok_r, ok_nxt, seen_r, seen_nxt;
  pacl_pkg::cmd_t cmd_r, cmd_nxt;
  logic [CW-1:0]  n_lim;
  logic           cmatch, ceq, srv_hit;
  logic [31:0]    mask;

  assign n_lim = (32'(rule_count) > MAX_RULES) ? CW'(MAX_RULES) : CW'(rule_count);

  assign ram_waddr = AW'(q_data.idx);
  assign ram_wdata = q_data.rule;
  assign mask      = pacl_pkg::prefix_mask(ram_rdata.prefix);
  assign srv_hit   = ((ram_rdata.address ^ cmd_r.srv) & mask) == '0;
  assign cmatch    = !ram_rdata.is_server && (((ram_rdata.address ^ cmd_r.cli) & mask) == '0);
  assign ceq       = (!ram_rdata.has_cookie && !cmd_r.rhas)
                  || (ram_rdata.has_cookie && cmd_r.rhas && ram_rdata.cookie == cmd_r.rtok);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    srvf_nxt  = srvf_r;
    found_nxt = found_r;
    ok_nxt    = ok_r;
    seen_nxt  = seen_r;
    cmd_nxt   = cmd_r;
    q_pop     = 1'b0;
    res_push  = 1'b0;
    res_data  = '{allowed: 1'b0, outcome: pacl_pkg::OUT_DENIED};
    ram_we    = 1'b0;
    ram_raddr = AW'(idx_r + 1'b1);
    unique case (state_r)
      S_IDLE: begin
        ram_raddr = '0;
        if (!q_empty && !res_full) begin
          q_pop = 1'b1;
          unique case (q_data.op)
            pacl_pkg::OP_WRITE: begin
              ram_we   = q_data.idx_ok;
              res_push = 1'b1;
              res_data = '{allowed: 1'b0, outcome: pacl_pkg::OUT_WRITTEN};
            end
            pacl_pkg::OP_LOCAL: begin
              res_push = 1'b1;
              res_data = '{allowed: 1'b1, outcome: pacl_pkg::OUT_LOCALHOST};
            end
            pacl_pkg::OP_CHECK: begin
              if (n_lim == '0) begin
                res_push = 1'b1;
              end else begin
                state_nxt = S_WALK;
                idx_nxt   = '0;
                srvf_nxt  = 1'b0;
                found_nxt = 1'b0;
                ok_nxt    = 1'b0;
                seen_nxt  = 1'b0;
                cmd_nxt   = q_data;
              end
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      S_WALK: begin
        if (res_full) begin
          // keep the current rule on the read port until a result slot frees
          ram_raddr = AW'(idx_r);
        end else if (!ram_rdata.is_server && !srvf_r) begin
          res_push  = 1'b1;
          res_data  = '{allowed: 1'b0, outcome: pacl_pkg::OUT_NO_SERVER};
          state_nxt = S_IDLE;
        end else begin
          srvf_nxt  = srvf_r || (ram_rdata.is_server && srv_hit);
          found_nxt = found_r || cmatch;
          ok_nxt    = ok_r || (found_nxt && ceq);
          // cookie presence counted from the latest matching client rule on
          seen_nxt  = cmatch ? ram_rdata.has_cookie : (seen_r || ram_rdata.has_cookie);
          if (idx_r == n_lim - CW'(1)) begin
            res_push  = 1'b1;
            state_nxt = S_IDLE;
            if (ok_nxt || (found_nxt && !seen_nxt)) begin
              res_data = '{allowed: 1'b1, outcome: pacl_pkg::OUT_ALLOWED};
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      srvf_r  <= 1'b0;
      found_r <= 1'b0;
      ok_r    <= 1'b0;
      seen_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      srvf_r  <= srvf_nxt;
      found_r <= found_nxt;
      ok_r    <= ok_nxt;
      seen_r  <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  `PACL_ASSERT(a_walk_in_range, (state_r == S_WALK) |-> (idx_r < n_lim))
  `PACL_NEVER(a_push_when_full, res_push && res_full)
  `PACL_ASSERT(a_walk_holds_queue, (state_r == S_WALK) |-> !q_pop)

endmodule

// ===== rtl/prefix_acl_server_client_check_unit.sv =====
// Top level of the prefix access list with server and client rules.
//
// Input channel (in_*): push an item while full is low. command 0 writes one
// rule at rule_index; command 1 checks server_address, client_address and the
// request cookie against the rules in use.
// Result channel (out_*): while empty is low the oldest result is shown;
// pop takes it. One result per input item, in order.
// Configuration (cfg_*): cfg_data sets the number of rules in use; write it
// only while no item is in flight. cfg_ready is always high.
// The back end takes an item the cycle after its transfer at the earliest;
// a write, a localhost check or a check with no rules in use is in the result
// queue at that same edge; other checks read one rule per cycle on the table's
// read port while the result queue has room, up to the last rule in use (at
// most MAX_RULES). A check may end early at a client rule seen before any
// server match. Command and result queues are two deep; when the receiver
// stalls the result queue fills, the back end stops and then full rises at
// the input. Reset empties both queues and clears the rule count; rule
// entries are undefined until written.
`timescale 1ns / 1ps
module prefix_acl_server_client_check_unit #(
  parameter int MAX_RULES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        full,
  input  logic        in_command,
  input  logic [3:0]  in_rule_index,
  input  logic        in_rule_is_server,
  input  logic [31:0] in_rule_address,
  input  logic [5:0]  in_rule_prefix,
  input  logic        in_rule_has_cookie,
  input  logic [63:0] in_rule_cookie,
  input  logic [31:0] in_server_address,
  input  logic [31:0] in_client_address,
  input  logic        in_request_has_cookie,
  input  logic [63:0] in_request_cookie,
  output logic        empty,
  input  logic        pop,
  output logic        out_allowed,
  output logic [2:0]  out_outcome,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CMD_W = $bits(pacl_pkg::cmd_t);
  localparam int RES_W = $bits(pacl_pkg::result_t);
  localparam int RULE_W = $bits(pacl_pkg::rule_t);

  logic [4:0]        rule_count_r;
  logic              q_push, q_full, q_pop, q_empty;
  pacl_pkg::cmd_t    q_wdata;
  logic [CMD_W-1:0]  q_rdata;
  logic              res_push, res_full;
  pacl_pkg::result_t res_wdata;
  logic [RES_W-1:0]  res_rdata;
  pacl_pkg::result_t res_out;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  pacl_pkg::rule_t   ram_wdata;
  logic [RULE_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      rule_count_r <= cfg_data;
    end
  end

  pacl_front #(.MAX_RULES(MAX_RULES)) u_front (
    .in_push               (in_push),
    .in_full               (full),
    .in_command            (in_command),
    .in_rule_index         (in_rule_index),
    .in_rule_is_server     (in_rule_is_server),
    .in_rule_address       (in_rule_address),
    .in_rule_prefix        (in_rule_prefix),
    .in_rule_has_cookie    (in_rule_has_cookie),
    .in_rule_cookie        (in_rule_cookie),
    .in_server_address     (in_server_address),
    .in_client_address     (in_client_address),
    .in_request_has_cookie (in_request_has_cookie),
    .in_request_cookie     (in_request_cookie),
    .q_push                (q_push),
    .q_data                (q_wdata),
    .q_full                (q_full)
  );

  pacl_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  pacl_ram #(.WIDTH(RULE_W), .DEPTH(MAX_RULES)) u_rules (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pacl_back #(.MAX_RULES(MAX_RULES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rule_count (rule_count_r),
    .q_data     (pacl_pkg::cmd_t'(q_rdata)),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_wdata),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (pacl_pkg::rule_t'(ram_rdata))
  );

  pacl_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_out     = pacl_pkg::result_t'(res_rdata);
  assign out_allowed = res_out.allowed;
  assign out_outcome = res_out.outcome;

endmodule
